>>> design/ows_pkg.sv
package ows_pkg;

  // input opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_SLOT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROM_BYTES  = 1'b0;
  localparam logic CFG_DATA_BYTES = 1'b1;

  // bus commands
  localparam logic [7:0] BUS_SKIP_ROM = 8'hCC;
  localparam logic [7:0] BUS_READ_ROM = 8'h33;
  localparam logic [7:0] BUS_READ_MEM = 8'hF0;
  localparam logic [7:0] ADDR_LO_MASK = 8'h7F;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RESET,
    CMD_SLOT,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] addr;
    logic [7:0] value;
    logic       line;
  } cmd_t;

  typedef struct packed {
    logic       drive_low;
    logic       presence_pulse;
    logic       byte_done;
    logic [7:0] byte_value;
    logic [3:0] phase;
  } res_t;

  // reflected CRC8, polynomial x^8 + x^5 + x^4 + 1, LSB first
  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ data[i];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

endpackage

>>> design/onewire_slave_memory_responder.sv
// 1-Wire slave answering Skip ROM / Read Memory and Read ROM from a byte
// store that is loaded through load items beforehand. Each item (load, bus
// reset, time slot or no-op) yields exactly one result item: drive_low, presence,
// the completed byte when a slot ends one, and the protocol phase afterwards.
// Rate: one item per clock sustained while results are popped; each item
// passes the front queue, then the protocol engine writes its result into
// the result queue, where it waits to be popped. The single store read
// port is kept off the critical path by prefetching, every cycle, the byte
// the next completed slot may need, so no slot ever waits on the store.
// No clearing pass after reset: store entries must be loaded before they
// are read out. rom_bytes resets to 8 and data_bytes to 256; write them
// only while the block is idle.
module onewire_slave_memory_responder #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item input
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [7:0] load_address_i,
  input  logic [7:0] load_value_i,
  input  logic       line_bit_i,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic       drive_low_o,
  output logic       presence_pulse_o,
  output logic       byte_done_o,
  output logic [7:0] byte_value_o,
  output logic [3:0] phase_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i
);
  import ows_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  // front: takes items and classifies them into engine commands
  ows_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .load_address_i (load_address_i),
    .load_value_i   (load_value_i),
    .line_bit_i     (line_bit_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // back: protocol state, CRC, byte store
  ows_engine #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue: decouples the engine from the consumer's pop
  ows_res_q u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign drive_low_o      = res_out.drive_low;
  assign presence_pulse_o = res_out.presence_pulse;
  assign byte_done_o      = res_out.byte_done;
  assign byte_value_o     = res_out.byte_value;
  assign phase_o          = res_out.phase;

endmodule

>>> design/ows_front.sv
module ows_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        load_address_i,
  input  logic [7:0]        load_value_i,
  input  logic              line_bit_i,
  output logic              cmd_valid_o,
  output ows_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import ows_pkg::*;

  cmd_t       slot_q [2];
  cmd_t       dec;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  // classify the incoming item
  always_comb begin
    dec.addr  = load_address_i;
    dec.value = load_value_i;
    dec.line  = line_bit_i;
    unique case (opcode_i)
      OP_LOAD:  dec.kind = CMD_LOAD;
      OP_RESET: dec.kind = CMD_RESET;
      OP_SLOT:  dec.kind = CMD_SLOT;
      OP_NONE:  dec.kind = CMD_NOP;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> design/ows_engine.sv
module ows_engine #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ows_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [8:0]    cfg_data_i,
  input  logic          res_full_i,
  output logic          res_push_o,
  output ows_pkg::res_t res_o
);
  import ows_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ROM_CMD  = 4'd1;
  localparam logic [3:0] PH_FUNC_CMD = 4'd2;
  localparam logic [3:0] PH_ADDR_LO  = 4'd3;
  localparam logic [3:0] PH_ADDR_HI  = 4'd4;
  localparam logic [3:0] PH_ADDR_CRC = 4'd5;
  localparam logic [3:0] PH_ROM_READ = 4'd6;
  localparam logic [3:0] PH_MEM_READ = 4'd7;
  localparam logic [3:0] PH_MEM_CRC  = 4'd8;

  logic [6:0]  rom_q;
  logic [8:0]  data_q;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] shift_q, shift_d;
  logic [3:0]  bits_q, bits_d;
  logic [8:0]  rp_q, rp_d;
  logic [7:0]  crc_q, crc_d;

  logic [7:0]  store [STORE_DEPTH];
  logic [7:0]  rd_data_q;
  logic        rd_oor_q;
  logic [8:0]  pf_ptr;
  logic [AW-1:0] rd_idx, wr_idx;
  logic        mem_we;

  logic        fire;
  logic [15:0] slot_shift;
  logic        slot_line;
  logic [7:0]  in_byte, rd_byte, send_byte, crc_hi;
  logic [8:0]  mem_start;
  logic        do_send;

  assign fire       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign rd_byte   = rd_oor_q ? 8'hFF : rd_data_q;
  assign mem_start = rp_q + {2'b00, rom_q};
  assign crc_hi    = crc8(crc_q, 8'h00);

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    rp_d       = rp_q;
    crc_d      = crc_q;
    res_o      = '0;
    mem_we     = 1'b0;
    do_send    = 1'b0;
    send_byte  = 8'h00;
    slot_line  = cmd_i.line & ~shift_q[0];
    slot_shift = {slot_line, shift_q[15:1]};
    in_byte    = slot_shift[15:8];
    if (fire) begin
      unique case (cmd_i.kind)
        CMD_LOAD: begin
          mem_we = (32'(cmd_i.addr) < STORE_DEPTH);
        end
        CMD_RESET: begin
          res_o.presence_pulse = 1'b1;
          phase_d = PH_ROM_CMD;
          shift_d = 16'h0000;
          bits_d  = 4'd8;
        end
        CMD_SLOT: begin
          if (phase_q != PH_IDLE) begin
            res_o.drive_low = shift_q[0];
            bits_d  = bits_q - 4'd1;
            shift_d = slot_shift;
            if (bits_d == 4'd0) begin
              shift_d = {8'h00, in_byte};
              res_o.byte_done  = 1'b1;
              res_o.byte_value = in_byte;
              unique case (phase_q)
                PH_ROM_CMD: begin
                  if (in_byte == BUS_SKIP_ROM) begin
                    phase_d = PH_FUNC_CMD;
                    shift_d = 16'h0000;
                    bits_d  = 4'd8;
                  end else if (in_byte == BUS_READ_ROM) begin
                    phase_d   = PH_ROM_READ;
                    rp_d      = 9'd1;
                    do_send   = 1'b1;
                    send_byte = rd_byte;
                  end else begin
                    phase_d = PH_IDLE;
                    shift_d = 16'h0000;
                  end
                end
                PH_ROM_READ: begin
                  if (rp_q < {2'b00, rom_q}) begin
                    do_send   = 1'b1;
                    send_byte = rd_byte;
                    rp_d      = rp_q + 9'd1;
                  end else begin
                    phase_d = PH_IDLE;
                    shift_d = 16'h0000;
                  end
                end
                PH_FUNC_CMD: begin
                  if (in_byte == BUS_READ_MEM) begin
                    crc_d   = crc8(8'h00, in_byte);
                    phase_d = PH_ADDR_LO;
                    shift_d = 16'h0000;
                    bits_d  = 4'd8;
                  end else begin
                    phase_d = PH_IDLE;
                    shift_d = 16'h0000;
                  end
                end
                PH_ADDR_LO: begin
                  rp_d    = {1'b0, in_byte & ADDR_LO_MASK};
                  crc_d   = crc8(crc_q, in_byte & ADDR_LO_MASK);
                  phase_d = PH_ADDR_HI;
                  shift_d = 16'h0000;
                  bits_d  = 4'd8;
                end
                PH_ADDR_HI: begin
                  crc_d     = crc_hi;
                  phase_d   = PH_ADDR_CRC;
                  do_send   = 1'b1;
                  send_byte = crc_hi;
                end
                PH_ADDR_CRC: begin
                  crc_d     = crc8(8'h00, rd_byte);
                  phase_d   = PH_MEM_READ;
                  do_send   = 1'b1;
                  send_byte = rd_byte;
                  rp_d      = mem_start + 9'd1;
                end
                PH_MEM_READ: begin
                  if (rp_q < data_q) begin
                    crc_d     = crc8(crc_q, rd_byte);
                    do_send   = 1'b1;
                    send_byte = rd_byte;
                    rp_d      = rp_q + 9'd1;
                  end else begin
                    phase_d   = PH_MEM_CRC;
                    do_send   = 1'b1;
                    send_byte = crc_q;
                  end
                end
                default: begin
                  phase_d = PH_IDLE;
                  shift_d = 16'h0000;
                end
              endcase
              // sent bits are stored inverted: a one means pull the line low
              if (do_send) begin
                shift_d = {8'hFF, ~send_byte};
                bits_d  = 4'd8;
              end
            end
          end
        end
        CMD_NOP: ;
      endcase
    end
    res_o.phase = phase_d;
  end

  // prefetch the byte the next completed slot could need
  always_comb begin
    unique case (phase_d)
      PH_ROM_CMD:  pf_ptr = 9'd0;
      PH_ADDR_CRC: pf_ptr = rp_d + {2'b00, rom_q};
      default:     pf_ptr = rp_d;
    endcase
  end

  assign rd_idx = AW'(pf_ptr);
  assign wr_idx = AW'(cmd_i.addr);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[wr_idx] <= cmd_i.value;
    end
    if (mem_we && (wr_idx == rd_idx)) begin
      rd_data_q <= cmd_i.value;
    end else begin
      rd_data_q <= store[rd_idx];
    end
    rd_oor_q <= (32'(pf_ptr) >= STORE_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q   <= 7'd8;
      data_q  <= 9'd256;
      phase_q <= PH_IDLE;
      shift_q <= 16'h0000;
      bits_q  <= 4'd0;
      rp_q    <= 9'd0;
      crc_q   <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROM_BYTES:  rom_q  <= cfg_data_i[6:0];
          CFG_DATA_BYTES: data_q <= cfg_data_i;
        endcase
      end
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      rp_q    <= rp_d;
      crc_q   <= crc_d;
    end
  end

endmodule

>>> design/ows_res_q.sv
module ows_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  input  ows_pkg::res_t res_i,
  output logic          res_full_o,
  output logic          empty,
  input  logic          pop,
  output ows_pkg::res_t res_o
);
  import ows_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign res_full_o = (count_q == 2'd2);
  assign empty      = (count_q == 2'd0);
  assign res_o      = slot_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sim/onewire_slave_memory_responder_test.sv
`timescale 1ns / 1ps
module onewire_slave_memory_responder_test;
  import ows_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int SETTLE_CYCLES = 8;      // settling wait after the queues drain, with margin for the last result
  localparam int HOLD_AT = 450;          // results seen before the long receiver stall
  localparam int HOLD_MIN_QUEUED = 16;   // items still to offer when the stall starts
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;     // cycles with no item moving on either side
  localparam logic [7:0] BUS_UNKNOWN = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROM_CMD, ST_FUNC_CMD, ST_ADDR_LO, ST_ADDR_HI,
    ST_ADDR_CRC, ST_ROM_READ, ST_MEM_READ, ST_MEM_CRC
  } bus_phase_e;

  // DUT connections, all driven to known values from time zero
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic [1:0] opcode_i = '0;
  logic [7:0] load_address_i = '0;
  logic [7:0] load_value_i = '0;
  logic       line_bit_i = 1'b0;
  logic       pop = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  wire        full, empty;
  wire        drive_low_o, presence_pulse_o, byte_done_o;
  wire  [7:0] byte_value_o;
  wire  [3:0] phase_o;

  onewire_slave_memory_responder #(.STORE_DEPTH(STORE_DEPTH)) u_dut (
    .clk_i, .rst_ni,
    .push, .full, .opcode_i, .load_address_i, .load_value_i, .line_bit_i,
    .empty, .pop, .drive_low_o, .presence_pulse_o, .byte_done_o, .byte_value_o, .phase_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Slave model: own copy of the registers and the protocol state
  // ---------------------------------------------------------------------------
  logic [6:0]  rom_len;
  logic [8:0]  data_end;
  bus_phase_e  bus_phase;
  logic [15:0] shift_reg;     // bits to send, inverted so a 1 means pull low
  logic [3:0]  bits_to_go;
  logic [8:0]  rd_ptr;
  logic [7:0]  crc_acc;
  logic [7:0]  mem_image [STORE_DEPTH];

  cmd_t queued_commands [$];  // items waiting for the driver
  res_t expected_answers [$]; // predicted results, oldest first

  // Dallas CRC8, one data bit per step, written as the shift register taps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ data[k];
      c  = {fb, c[7:5], c[4] ^ fb, c[3] ^ fb, c[2:1]};
    end
    return c;
  endfunction

  // past the end of the store the line floats high
  function automatic logic [7:0] store_byte(input logic [8:0] ptr);
    if (ptr >= STORE_DEPTH) begin
      return 8'hFF;
    end
    return mem_image[ptr[7:0]];
  endfunction

  function automatic void send_byte(input logic [7:0] v);
    bits_to_go = 4'd8;
    shift_reg  = {8'hFF, ~v};
  endfunction

  function automatic void await_byte();
    bits_to_go = 4'd8;
    shift_reg  = '0;
  endfunction

  function automatic void drop_to_idle();
    bus_phase = ST_IDLE;
    shift_reg = '0;
  endfunction

  // protocol step taken when eight bits have crossed the wire
  function automatic void byte_complete(input logic [7:0] b);
    logic [7:0] v;
    case (bus_phase)
      ST_ROM_CMD: begin
        if (b == BUS_SKIP_ROM) begin
          bus_phase = ST_FUNC_CMD;
          await_byte();
        end else if (b == BUS_READ_ROM) begin
          bus_phase = ST_ROM_READ;
          rd_ptr    = 9'd1;
          send_byte(store_byte(9'd0));
        end else begin
          drop_to_idle();
        end
      end
      ST_ROM_READ: begin
        if (rd_ptr < rom_len) begin
          send_byte(store_byte(rd_ptr));
          rd_ptr = rd_ptr + 9'd1;
        end else begin
          drop_to_idle();
        end
      end
      ST_FUNC_CMD: begin
        if (b == BUS_READ_MEM) begin
          crc_acc   = crc8_step(8'h00, b);
          bus_phase = ST_ADDR_LO;
          await_byte();
        end else begin
          drop_to_idle();
        end
      end
      ST_ADDR_LO: begin
        rd_ptr    = 9'(b & ADDR_LO_MASK);
        crc_acc   = crc8_step(crc_acc, b & ADDR_LO_MASK);
        bus_phase = ST_ADDR_HI;
        await_byte();
      end
      ST_ADDR_HI: begin
        // high address byte is ignored, the CRC sees it as zero
        crc_acc   = crc8_step(crc_acc, 8'h00);
        bus_phase = ST_ADDR_CRC;
        send_byte(crc_acc);
      end
      ST_ADDR_CRC: begin
        // first data byte goes out even when already past the end
        rd_ptr    = rd_ptr + rom_len;
        v         = store_byte(rd_ptr);
        crc_acc   = crc8_step(8'h00, v);
        bus_phase = ST_MEM_READ;
        send_byte(v);
        rd_ptr    = rd_ptr + 9'd1;
      end
      ST_MEM_READ: begin
        if (rd_ptr < data_end) begin
          v       = store_byte(rd_ptr);
          crc_acc = crc8_step(crc_acc, v);
          send_byte(v);
          rd_ptr  = rd_ptr + 9'd1;
        end else begin
          bus_phase = ST_MEM_CRC;
          send_byte(crc_acc);
        end
      end
      default: drop_to_idle();
    endcase
  endfunction

  // one result per item; read pointer and CRC survive a bus reset
  function automatic res_t slave_answer(input cmd_t c);
    res_t r;
    logic ln;
    r  = '0;
    ln = c.line;
    case (c.kind)
      CMD_LOAD: mem_image[c.addr] = c.value;
      CMD_RESET: begin
        r.presence_pulse = 1'b1;
        bus_phase        = ST_ROM_CMD;
        await_byte();
      end
      CMD_SLOT: begin
        if (bus_phase != ST_IDLE) begin
          r.drive_low = shift_reg[0];
          if (shift_reg[0]) begin
            ln = 1'b0;            // our own pull-down wins on the wire
          end
          bits_to_go = bits_to_go - 4'd1;
          shift_reg  = {ln, shift_reg[15:1]};
          if (bits_to_go == 4'd0) begin
            shift_reg    = shift_reg >> 8;
            r.byte_done  = 1'b1;
            r.byte_value = shift_reg[7:0];
            byte_complete(shift_reg[7:0]);
          end
        end
      end
      default: ;                  // no-op item
    endcase
    r.phase = bus_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item queue helpers
  // ---------------------------------------------------------------------------
  int items_queued = 0;

  function automatic void queue_cmd(input cmd_kind_e k, input logic [7:0] a,
                                    input logic [7:0] v, input logic ln);
    cmd_t c;
    c.kind  = k;
    c.addr  = a;
    c.value = v;
    c.line  = ln;
    queued_commands.push_back(c);
    items_queued++;
  endfunction

  function automatic void queue_slot(input logic ln);
    queue_cmd(CMD_SLOT, 8'($urandom), 8'($urandom), ln);
  endfunction

  function automatic void queue_bus_reset();
    queue_cmd(CMD_RESET, 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  // master writes a byte, LSB first
  function automatic void queue_byte(input logic [7:0] b);
    for (int k = 0; k < 8; k++) begin
      queue_slot(b[k]);
    end
  endfunction

  // read slots: master mostly releases the line, sometimes pulls it low
  function automatic void queue_reads(input int n);
    for (int k = 0; k < n; k++) begin
      queue_slot($urandom_range(3) != 0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, runs the model on each accepted one
  // ---------------------------------------------------------------------------
  int   sender_idle_pct = 0;
  int   receiver_idle_pct = 0;
  cmd_t driven_item;
  cmd_t next_item;
  int   loads_taken = 0, resets_taken = 0, slots_taken = 0, nops_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_answers.push_back(slave_answer(driven_item));
        case (driven_item.kind)
          CMD_LOAD:  loads_taken++;
          CMD_RESET: resets_taken++;
          CMD_SLOT:  slots_taken++;
          default:   nops_taken++;
        endcase
      end
      if (push && full) begin
        // item still waiting: hold it steady
      end else if (queued_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item      = queued_commands.pop_front();
        driven_item    = next_item;
        push           <= 1'b1;
        opcode_i       <= next_item.kind;
        load_address_i <= next_item.addr;
        load_value_i   <= next_item.value;
        line_bit_i     <= next_item.line;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops results and checks each against the oldest prediction
  // ---------------------------------------------------------------------------
  int   mismatches = 0;
  int   results_checked = 0;
  int   bytes_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  res_t want;

  function automatic void compare_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      hold_left <= 0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (byte_done_o) begin
          bytes_seen++;
        end
        if (expected_answers.size() == 0) begin
          $error("result with nothing expected (phase %0d)", phase_o);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          compare_field("drive_low", 8'(want.drive_low), 8'(drive_low_o));
          compare_field("presence_pulse", 8'(want.presence_pulse), 8'(presence_pulse_o));
          compare_field("byte_done", 8'(want.byte_done), 8'(byte_done_o));
          compare_field("byte_value", want.byte_value, byte_value_o);
          compare_field("phase", 8'(want.phase), 8'(phase_o));
        end
      end
      // one long stall so the block backs up and pushes back on the sender
      if (hold_left != 0) begin
        pop       <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AT &&
                   queued_commands.size() > HOLD_MIN_QUEUED) begin
        pop       <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // watchdog: no item moving on either side for too long
  int stall_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic wait_until_drained();
    while (queued_commands.size() != 0 || push || expected_answers.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == CFG_ROM_BYTES) begin
      rom_len = val[6:0];
    end else begin
      data_end = val;
    end
  endtask

  initial begin
    int         rom_table [PHASES];
    int         data_table [PHASES];
    int         rom_v, data_v, target, tail, pick, addr_goal;
    logic [7:0] lo;
    // defaults, low extremes, high extremes, out of range, zero, random
    rom_table  = '{8, 1, 64, 127, 0, 0};
    data_table = '{256, 1, 256, 511, 0, 0};

    rom_len    = 7'd8;
    data_end   = 9'd256;
    bus_phase  = ST_IDLE;
    shift_reg  = '0;
    bits_to_go = '0;
    rd_ptr     = '0;
    crc_acc    = '0;
    foreach (mem_image[i]) begin
      mem_image[i] = 8'h00;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk_i);
        rom_v  = rom_table[p];
        data_v = data_table[p];
        if (p == PHASES - 1) begin
          rom_v  = $urandom_range(1, 64);
          data_v = $urandom_range(rom_v + 1, 256);
        end
        write_reg(CFG_ROM_BYTES, 9'(rom_v));
        write_reg(CFG_DATA_BYTES, 9'(data_v));
        cfg_we_i <= 1'b0;
      end

      // idling: receiver-heavy, then sender-heavy, then none
      if (p < 2) begin
        sender_idle_pct   = 34;
        receiver_idle_pct = 47;
      end else if (p < 4) begin
        sender_idle_pct   = 47;
        receiver_idle_pct = 34;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end

      if (p == 0) begin
        // fill the whole store first so no read ever hits an unwritten entry
        for (int a = 0; a < STORE_DEPTH; a++) begin
          queue_cmd(CMD_LOAD, 8'(a), 8'($urandom), 1'($urandom));
        end
        // slots while idle are ignored
        queue_slot(1'b0);
        queue_slot(1'b1);
        queue_cmd(CMD_NOP, 8'hFF, 8'hFF, 1'b1);
        queue_cmd(CMD_LOAD, 8'h00, 8'h00, 1'b0);
        queue_cmd(CMD_LOAD, 8'hFF, 8'hFF, 1'b1);
        // unknown ROM command drops to idle
        queue_bus_reset();
        queue_byte(BUS_UNKNOWN);
        // Read ROM and the start of the identity stream
        queue_bus_reset();
        queue_byte(BUS_READ_ROM);
        queue_slot(1'b1);
        queue_slot(1'b0);
      end

      target = items_queued + RANDOM_PER_PHASE;
      while (items_queued < target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // Skip ROM + Read Memory; address often chosen near the end of data
          queue_bus_reset();
          queue_byte(BUS_SKIP_ROM);
          queue_byte(BUS_READ_MEM);
          addr_goal = int'(data_end) - int'(rom_len) - int'($urandom_range(3));
          if ($urandom_range(1) != 0) begin
            lo = 8'($urandom);
          end else if (addr_goal >= 0 && addr_goal <= 127) begin
            lo = {1'($urandom), 7'(addr_goal)};
          end else begin
            lo = 8'h7F - 8'($urandom_range(3));
          end
          queue_byte(lo);
          queue_byte(8'($urandom));
          tail = 8 + 8 * $urandom_range(0, 5) + $urandom_range(7);
          if ($urandom_range(9) == 0) begin
            tail += 8 * $urandom_range(5, 20);
          end
          queue_reads(tail);
        end else if (pick < 75) begin
          // Read ROM, sometimes run past the identity bytes
          queue_bus_reset();
          queue_byte(BUS_READ_ROM);
          queue_reads(8 * $urandom_range(0, 3) + $urandom_range(7));
        end else begin
          // noise and broken sequences
          case ($urandom_range(4))
            0: queue_cmd(CMD_LOAD, 8'($urandom), 8'($urandom), 1'($urandom));
            1: queue_cmd(CMD_NOP, 8'($urandom), 8'($urandom), 1'($urandom));
            2: queue_slot(1'($urandom));
            3: begin
              queue_bus_reset();
              queue_byte(8'($urandom));
              queue_reads($urandom_range(0, 10));
            end
            default: begin
              queue_bus_reset();
              queue_byte(BUS_SKIP_ROM);
              queue_byte(8'($urandom));
              queue_reads($urandom_range(0, 10));
            end
          endcase
        end
      end
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items: %0d store loads, %0d bus resets, %0d slots, %0d no-ops,",
             loads_taken + resets_taken + slots_taken + nops_taken,
             loads_taken, resets_taken, slots_taken, nops_taken);
    $display("%0d results checked (%0d bytes on the wire) over %0d register settings.",
             results_checked, bytes_seen, PHASES);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/ows_pkg.sv
design/ows_front.sv
design/ows_engine.sv
design/ows_res_q.sv
design/onewire_slave_memory_responder.sv
sim/onewire_slave_memory_responder_test.sv
